FILE: hdl/lpdx_pkg.sv
// ============================================================================
// lpdx_pkg
// Shared constants, codes and types for the length-prefixed deframer.
// ============================================================================
package lpdx_pkg;

   // Sizing
   localparam int BUFFER_BYTES = 4096;
   localparam int KEY_BYTES    = 8;
   localparam int HEADER_BYTES = 6;

   localparam int BUF_POS_W = $clog2(BUFFER_BYTES + 1);
   localparam int KEY_POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   localparam logic [BUF_POS_W-1:0] BUF_LIMIT = BUF_POS_W'(BUFFER_BYTES);
   localparam logic [15:0]          HDR_LEN   = 16'(HEADER_BYTES);

   // Key register reset: bytes cb 1e bd 4c bf 8f b9 4a, byte 0 lowest
   localparam logic [63:0] KEY_RESET = 64'h4AB9_8FBF_4CBD_1ECB;

   // Header position codes
   localparam logic [2:0] HDR_LEN_LO  = 3'd0;
   localparam logic [2:0] HDR_LEN_HI  = 3'd1;
   localparam logic [2:0] HDR_OP_LO   = 3'd2;
   localparam logic [2:0] HDR_OP_HI   = 3'd3;
   localparam logic [2:0] HDR_CRYPT   = 3'd4;
   localparam logic [2:0] HDR_SPARE   = 3'd5;
   localparam logic [2:0] HDR_PAYLOAD = 3'd6;

   // Byte kind codes
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_IGNORED = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_SHORT   = 2'd1;
   localparam logic [1:0] ERR_OVERRUN = 2'd2;

   // Crypt flag values that enable the XOR
   localparam logic [7:0] CRYPT_ON_A = 8'd1;
   localparam logic [7:0] CRYPT_ON_B = 8'd2;

   typedef struct packed {
      logic [2:0]           header_pos;
      logic [15:0]          frame_length;
      logic [15:0]          current_opcode;
      logic                 crypt_active;
      logic [15:0]          payload_left;
      logic [KEY_POS_W-1:0] key_pos;
      logic [BUF_POS_W-1:0] buffer_pos;
      logic                 halted;
      logic                 first_in_buffer;
   } lpdx_state_type;

   // State after reset: halted, waiting for a buffer start
   localparam lpdx_state_type STATE_RESET = '{
      header_pos:      HDR_LEN_LO,
      frame_length:    16'd0,
      current_opcode:  16'd0,
      crypt_active:    1'b0,
      payload_left:    16'd0,
      key_pos:         '0,
      buffer_pos:      '0,
      halted:          1'b1,
      first_in_buffer: 1'b1
   };

   typedef struct packed {
      logic [1:0]  byte_kind;
      logic [7:0]  data_out;
      logic [15:0] packet_opcode;
      logic        packet_end;
      logic [1:0]  error_code;
   } lpdx_result_type;

endpackage

FILE: hdl/lpdx_step.sv
// ============================================================================
// lpdx_step
// Per-byte deframer logic: next state and result for one input item.
// ============================================================================
module lpdx_step import lpdx_pkg::*; (
   input  lpdx_state_type  state_cur,
   input  logic [7:0]      data_byte,
   input  logic            buffer_start,
   input  logic [63:0]     xor_key,
   output lpdx_state_type  state_nxt,
   output lpdx_result_type result
);

   lpdx_state_type        st;
   logic [2:0]            key_idx;
   logic [7:0]            key_byte;
   logic [KEY_POS_W:0]    key_inc;
   logic [15:0]           len_full;
   logic [15:0]           op_full;
   logic [15:0]           left_dec;

   always_comb begin
      st = state_cur;

      // New buffer drops any packet in progress
      if (buffer_start) begin
         st.halted          = 1'b0;
         st.first_in_buffer = 1'b1;
         st.header_pos      = HDR_LEN_LO;
         st.buffer_pos      = '0;
         st.payload_left    = '0;
         st.key_pos         = '0;
      end

      key_idx  = 3'(st.key_pos);
      key_byte = xor_key[{key_idx, 3'b000} +: 8];
      key_inc  = {1'b0, st.key_pos} + 1'b1;
      len_full = {data_byte, st.frame_length[7:0]};
      op_full  = {data_byte, st.current_opcode[7:0]};
      left_dec = st.payload_left - 16'd1;

      result.byte_kind     = KIND_IGNORED;
      result.data_out      = data_byte;
      result.packet_opcode = '0;
      result.packet_end    = 1'b0;
      result.error_code    = ERR_NONE;

      if (!st.halted) begin
         if (st.header_pos == HDR_LEN_LO && !st.first_in_buffer &&
             st.buffer_pos >= BUF_LIMIT) begin
            // Next packet would start past the buffer
            result.byte_kind  = KIND_ERROR;
            result.error_code = ERR_OVERRUN;
            st.halted         = 1'b1;
         end else begin
            if (st.buffer_pos < BUF_LIMIT) begin
               st.buffer_pos = st.buffer_pos + 1'b1;
            end
            result.byte_kind = KIND_HEADER;
            case (st.header_pos)
               HDR_LEN_LO: begin
                  st.frame_length = {8'd0, data_byte};
                  st.header_pos   = HDR_LEN_HI;
               end
               HDR_LEN_HI: begin
                  st.frame_length = len_full;
                  // zero length on a later packet ends the buffer quietly
                  if (!st.first_in_buffer && len_full == 16'd0) begin
                     st.halted     = 1'b1;
                     st.header_pos = HDR_LEN_LO;
                  end else begin
                     st.header_pos = HDR_OP_LO;
                  end
               end
               HDR_OP_LO: begin
                  st.current_opcode = {8'd0, data_byte};
                  st.header_pos     = HDR_OP_HI;
               end
               HDR_OP_HI: begin
                  st.current_opcode    = op_full;
                  result.packet_opcode = op_full;
                  st.header_pos        = HDR_CRYPT;
               end
               HDR_CRYPT: begin
                  st.crypt_active = (data_byte == CRYPT_ON_A) ||
                                    (data_byte == CRYPT_ON_B);
                  result.packet_opcode = st.current_opcode;
                  st.header_pos        = HDR_SPARE;
               end
               HDR_SPARE: begin
                  result.packet_opcode = st.current_opcode;
                  if (st.frame_length < HDR_LEN) begin
                     result.byte_kind  = KIND_ERROR;
                     result.error_code = ERR_SHORT;
                     st.halted         = 1'b1;
                     st.header_pos     = HDR_LEN_LO;
                  end else begin
                     st.payload_left    = st.frame_length - HDR_LEN;
                     st.key_pos         = '0;
                     st.first_in_buffer = 1'b0;
                     if (st.frame_length == HDR_LEN) begin
                        result.packet_end = 1'b1;
                        st.header_pos     = HDR_LEN_LO;
                     end else begin
                        st.header_pos = HDR_PAYLOAD;
                     end
                  end
               end
               default: begin
                  // Payload byte, optional repeating-key XOR
                  result.byte_kind     = KIND_PAYLOAD;
                  result.packet_opcode = st.current_opcode;
                  if (st.crypt_active) begin
                     result.data_out = data_byte ^ key_byte;
                  end
                  if (key_inc >= (KEY_POS_W+1)'(KEY_BYTES)) begin
                     st.key_pos = '0;
                  end else begin
                     st.key_pos = key_inc[KEY_POS_W-1:0];
                  end
                  if (st.payload_left != 16'd0) begin
                     st.payload_left = left_dec;
                  end
                  if (st.payload_left == 16'd0) begin
                     result.packet_end = 1'b1;
                     st.header_pos     = HDR_LEN_LO;
                  end
               end
            endcase
         end
      end

      state_nxt = st;
   end

endmodule

FILE: hdl/length_prefixed_deframer_xor.sv
// ============================================================================
// length_prefixed_deframer_xor
// Splits a byte stream into length-prefixed packets, XORs crypted payloads.
// ============================================================================
// Takes one byte per cycle while the result register has room, and returns one
// result item per byte in the cycle after acceptance. The per-byte state update
// (header position, length, payload count, key position) is combinational, so
// bytes stream at full rate; a result register with ready passed back from the
// output lets a new byte in while the previous result is being taken. The key
// register is to be written only while no byte is in flight.
module length_prefixed_deframer_xor import lpdx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_byte_kind,
   output logic [7:0]  rsp_data_out,
   output logic [15:0] rsp_packet_opcode,
   output logic        rsp_packet_end,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);

   lpdx_state_type  state_ff, state_in, step_state;
   lpdx_result_type rsp_ff, step_result;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     key_ff;
   logic            accept;

   // Handshake: room when the result register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lpdx_step u_step (
      .state_cur    (state_ff),
      .data_byte    (req_data_byte),
      .buffer_start (req_buffer_start),
      .xor_key      (key_ff),
      .state_nxt    (step_state),
      .result       (step_result)
   );

   assign state_in     = accept ? step_state : state_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // Control state and key register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
         key_ff       <= KEY_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            key_ff <= csr_write_data;
         end
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_kind     = rsp_ff.byte_kind;
   assign rsp_data_out      = rsp_ff.data_out;
   assign rsp_packet_opcode = rsp_ff.packet_opcode;
   assign rsp_packet_end    = rsp_ff.packet_end;
   assign rsp_error_code    = rsp_ff.error_code;

   // Error kind and error code always travel together
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.byte_kind == KIND_ERROR) ==
                        (rsp_ff.error_code != ERR_NONE)))
      else $error("error kind and error code disagree");

   // Packet end only on header or payload bytes
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.packet_end) |->
         (rsp_ff.byte_kind == KIND_HEADER || rsp_ff.byte_kind == KIND_PAYLOAD))
      else $error("packet end on ignored or error byte");

   // An error halts the deframer until the next buffer start
   a_err_halt: assert property (@(posedge clock) disable iff (reset)
      (accept && step_result.byte_kind == KIND_ERROR) |=> state_ff.halted)
      else $error("deframer not halted after error");

   // A buffer start always clears the halt
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_buffer_start) |-> (step_result.byte_kind != KIND_IGNORED))
      else $error("buffer start byte ignored");

endmodule

FILE: sim/deframe_checker.sv
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the deframer's channels, predicts each result item and compares.
// ----------------------------------------------------------------------------
// Every accepted input item is run through a local model of the deframer
// (header walk, length checks, buffer fill, payload XOR) and the predicted
// result item is queued. Each accepted result item is compared field by field
// with the oldest prediction. Key writes are picked up from the CSR port.
module deframe_checker import lpdx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_start,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_byte_kind,
   input  logic [7:0]  rsp_data_out,
   input  logic [15:0] rsp_packet_opcode,
   input  logic        rsp_packet_end,
   input  logic [1:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data,
   output int          mismatch_count,
   output int          bytes_in_flight,
   output int          packets_closed,
   output int          short_errors,
   output int          overruns,
   output int          payload_bytes
);
   timeunit 1ns;
   timeprecision 1ps;

   // Local copy of the deframer state and key
   logic [2:0]           hdr_pos;
   logic [15:0]          frame_len;
   logic [15:0]          opcode_q;
   logic                 crypt_on;
   logic [15:0]          payload_cnt;
   logic [KEY_POS_W-1:0] key_idx;
   logic [BUF_POS_W-1:0] buf_fill;
   logic                 halted_q;
   logic                 first_pkt;
   logic [63:0]          key_reg;

   lpdx_result_type predicted_outputs[$];

   // Advance the local state by one byte and return the result item it causes
   function automatic lpdx_result_type deframe_byte(input logic [7:0] b, input logic start);
      lpdx_result_type r;
      r.byte_kind     = KIND_IGNORED;
      r.data_out      = b;
      r.packet_opcode = '0;
      r.packet_end    = 1'b0;
      r.error_code    = ERR_NONE;

      // a new buffer drops whatever packet was in progress
      if (start) begin
         halted_q    = 1'b0;
         first_pkt   = 1'b1;
         hdr_pos     = HDR_LEN_LO;
         buf_fill    = '0;
         payload_cnt = '0;
         key_idx     = '0;
      end

      if (!halted_q) begin
         if (hdr_pos == HDR_LEN_LO && !first_pkt && buf_fill >= BUF_LIMIT) begin
            // later packet starting past the end of the buffer
            r.byte_kind  = KIND_ERROR;
            r.error_code = ERR_OVERRUN;
            halted_q     = 1'b1;
         end else begin
            if (buf_fill < BUF_LIMIT) buf_fill++;
            r.byte_kind = KIND_HEADER;
            case (hdr_pos)
               HDR_LEN_LO: begin
                  frame_len = {8'h00, b};
                  hdr_pos   = HDR_LEN_HI;
               end
               HDR_LEN_HI: begin
                  frame_len[15:8] = b;
                  // zero length on a later packet ends the buffer quietly
                  if (!first_pkt && frame_len == 16'h0000) begin
                     halted_q = 1'b1;
                     hdr_pos  = HDR_LEN_LO;
                  end else begin
                     hdr_pos = HDR_OP_LO;
                  end
               end
               HDR_OP_LO: begin
                  opcode_q = {8'h00, b};
                  hdr_pos  = HDR_OP_HI;
               end
               HDR_OP_HI: begin
                  opcode_q[15:8]  = b;
                  r.packet_opcode = opcode_q;
                  hdr_pos         = HDR_CRYPT;
               end
               HDR_CRYPT: begin
                  crypt_on        = (b == CRYPT_ON_A || b == CRYPT_ON_B);
                  r.packet_opcode = opcode_q;
                  hdr_pos         = HDR_SPARE;
               end
               HDR_SPARE: begin
                  r.packet_opcode = opcode_q;
                  if (frame_len < HDR_LEN) begin
                     r.byte_kind  = KIND_ERROR;
                     r.error_code = ERR_SHORT;
                     halted_q     = 1'b1;
                     hdr_pos      = HDR_LEN_LO;
                  end else begin
                     payload_cnt = frame_len - HDR_LEN;
                     key_idx     = '0;
                     first_pkt   = 1'b0;
                     if (payload_cnt == 16'h0000) begin
                        r.packet_end = 1'b1;
                        hdr_pos      = HDR_LEN_LO;
                     end else begin
                        hdr_pos = HDR_PAYLOAD;
                     end
                  end
               end
               default: begin
                  r.byte_kind     = KIND_PAYLOAD;
                  r.packet_opcode = opcode_q;
                  if (crypt_on) r.data_out = b ^ key_reg[8*key_idx +: 8];
                  key_idx = (int'(key_idx) + 1 >= KEY_BYTES) ? '0 : key_idx + 1'b1;
                  if (payload_cnt != 16'h0000) payload_cnt--;
                  if (payload_cnt == 16'h0000) begin
                     r.packet_end = 1'b1;
                     hdr_pos      = HDR_LEN_LO;
                  end
               end
            endcase
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Predict accepted items, track key writes, compare returned items
   always @(posedge clock) begin
      lpdx_result_type want;
      if (reset) begin
         hdr_pos     = HDR_LEN_LO;
         frame_len   = '0;
         opcode_q    = '0;
         crypt_on    = 1'b0;
         payload_cnt = '0;
         key_idx     = '0;
         buf_fill    = '0;
         halted_q    = 1'b1;
         first_pkt   = 1'b1;
         key_reg     = KEY_RESET;
         predicted_outputs.delete();
         bytes_in_flight <= 0;
      end else begin
         // an item taken on a key write edge still sees the old key
         if (req_valid && req_ready)
            predicted_outputs.push_back(deframe_byte(req_data_byte, req_buffer_start));
         if (csr_write_enable) key_reg = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("result item with nothing outstanding: kind %0d data 0x%02h",
                      rsp_byte_kind, rsp_data_out);
               mismatch_count++;
            end else begin
               want = predicted_outputs.pop_front();
               check_field("byte_kind", want.byte_kind, rsp_byte_kind);
               check_field("data_out", want.data_out, rsp_data_out);
               check_field("packet_opcode", want.packet_opcode, rsp_packet_opcode);
               check_field("packet_end", want.packet_end, rsp_packet_end);
               check_field("error_code", want.error_code, rsp_error_code);
               if (want.packet_end) packets_closed++;
               if (want.error_code == ERR_SHORT) short_errors++;
               if (want.error_code == ERR_OVERRUN) overruns++;
               if (want.byte_kind == KIND_PAYLOAD) payload_bytes++;
            end
         end
         bytes_in_flight <= predicted_outputs.size();
      end
   end

endmodule

FILE: sim/tb_length_prefixed_deframer_xor.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_deframer_xor
// Stimulus and verdict for the length-prefixed deframer with payload XOR.
// ----------------------------------------------------------------------------
// Feeds byte buffers into the deframer: a short directed set covering stray
// bytes, header-only packets, crypted payloads, zero-length stops and short
// lengths, one buffer long enough to overrun, then random buffers built mostly
// from well-formed packets plus truncated, short and noisy ones. The key is
// rewritten between phases. Both channels idle at random; one phase holds the
// receiver off long enough to back the block up. deframe_checker does the
// prediction and comparison.
module tb_length_prefixed_deframer_xor import lpdx_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_BYTES     = 340;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte    = '0;
   logic        req_buffer_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [1:0]  rsp_byte_kind;
   logic [7:0]  rsp_data_out;
   logic [15:0] rsp_packet_opcode;
   logic        rsp_packet_end;
   logic [1:0]  rsp_error_code;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data   = '0;

   int mismatch_count, bytes_in_flight, packets_closed, short_errors, overruns;
   int payload_bytes;
   int bytes_sent   = 0;
   int key_settings = 1;
   bit steady       = 1'b0;  // no idling on either side
   bit squeeze      = 1'b0;  // receiver takes one long hold-off
   bit fresh_buffer = 1'b0;  // next item carries buffer_start

   length_prefixed_deframer_xor u_dut (.*);

   deframe_checker u_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("run did not complete within the time limit");
      $display("TEST FAILED");
      $finish;
   end

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_crypt();
      case ($urandom_range(0, 3))
         0:       return CRYPT_ON_A;
         1:       return CRYPT_ON_B;
         2:       return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one byte and hold it until accepted
   task automatic feed(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_buffer_start <= fresh_buffer;
      fresh_buffer = 1'b0;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_noise(input int n);
      repeat (n) feed(8'($urandom));
   endtask

   // Header then payload, cut after limit bytes; short lengths still send six
   task automatic send_frame(input logic [15:0] len, input logic [15:0] op,
                             input logic [7:0] crypt, input int limit);
      int total;
      total = (len < HDR_LEN) ? HEADER_BYTES : int'(len);
      if (limit < total) total = limit;
      for (int i = 0; i < total; i++) begin
         if (i >= HEADER_BYTES) begin
            feed(8'($urandom));
         end else begin
            case (3'(i))
               HDR_LEN_LO: feed(len[7:0]);
               HDR_LEN_HI: feed(len[15:8]);
               HDR_OP_LO:  feed(op[7:0]);
               HDR_OP_HI:  feed(op[15:8]);
               HDR_CRYPT:  feed(crypt);
               default:    feed(8'($urandom));
            endcase
         end
      end
   endtask

   // One buffer: a few packets, usually well formed, sometimes broken
   task automatic send_random_buffer();
      int          packets;
      int          roll;
      logic [15:0] len;
      packets = $urandom_range(1, 4);
      fresh_buffer = 1'b1;
      for (int p = 0; p < packets; p++) begin
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            len = HDR_LEN + 16'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                             : $urandom_range(0, 12));
            send_frame(len, 16'($urandom), pick_crypt(), int'(len));
         end else if (roll < 80) begin
            // length under the header size, trailing bytes are ignored
            send_frame(16'($urandom_range(0, 5)), 16'($urandom), pick_crypt(), HEADER_BYTES);
            send_noise($urandom_range(0, 3));
            return;
         end else if (roll < 87 && p > 0) begin
            // zero length on a later packet stops the buffer
            send_frame(16'h0000, 16'($urandom), 8'h00, 2);
            send_noise($urandom_range(0, 3));
            return;
         end else if (roll < 94) begin
            // packet usually cut short, the next buffer start abandons it
            len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(7, 65535));
            send_frame(len, 16'($urandom), pick_crypt(), $urandom_range(1, 12));
            return;
         end else begin
            send_noise($urandom_range(1, 8));
            return;
         end
      end
   endtask

   // Stop offering and wait for every outstanding result item
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_in_flight != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] k);
      csr_write_enable <= 1'b1;
      csr_write_data   <= k;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      key_settings++;
   endtask

   // Receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            squeeze = 1'b0;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      logic [63:0] key;
      int          goal;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // stray bytes before any buffer start
      feed(8'h00);
      feed(8'hFF);
      // header-only packet, crypted packet, then a zero length stop
      fresh_buffer = 1'b1;
      send_frame(HDR_LEN, 16'hFFFF, CRYPT_ON_A, HEADER_BYTES);
      send_frame(16'd8, 16'h0000, CRYPT_ON_B, 8);
      send_frame(16'h0000, 16'hA55A, 8'h00, 2);
      feed(8'h5A);
      // zero length on the first packet is a short-length error
      fresh_buffer = 1'b1;
      send_frame(16'h0000, 16'h1234, 8'hFF, HEADER_BYTES);

      // fill a buffer: second packet starts one byte short of the limit and
      // runs past it, the third packet start overruns
      fresh_buffer = 1'b1;
      send_frame(16'(BUFFER_BYTES - 1), 16'($urandom), CRYPT_ON_A, BUFFER_BYTES);
      send_frame(16'd8, 16'($urandom), 8'h00, 8);
      send_noise(2);

      // random buffers under a range of keys
      for (int phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0:       key = '0;
            1:       key = '1;
            4:       key = KEY_RESET;
            default: key = {$urandom, $urandom};
         endcase
         write_key(key);
         steady  = (phase == 1 || phase == 3);
         squeeze = (phase == 1);
         goal = bytes_sent + PHASE_BYTES;
         while (bytes_sent < goal) send_random_buffer();
      end
      steady = 1'b0;
      settle();

      $display("Sent %0d bytes across %0d key settings; %0d packets closed, %0d payload bytes.",
               bytes_sent, key_settings, packets_closed, payload_bytes);
      $display("Errors hit: %0d short lengths, %0d overruns; receiver held off %0d cycles once.",
               short_errors, overruns, HOLD_OFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
